// ----- hw/rtl/assert_macros.svh -----
// Assertion macros shared by the RTL of the indirect id table engine.
// No dependencies; empty bodies when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif
`endif

// ----- hw/rtl/iite_pkg.sv -----
// Package of the indirect id table engine: sizes, codes, transfer types,
// microcode layout and control store. No dependencies.
package iite_pkg;

	localparam int TABLE_DEPTH = 1024;
	localparam int CHAIN_LIMIT = 63;

	localparam int ADDR_W  = $clog2(TABLE_DEPTH);
	localparam int USED_W  = $clog2(TABLE_DEPTH + 1);
	localparam int CNT_W   = $clog2(CHAIN_LIMIT + 1);
	localparam int KIDX_W  = 22;
	localparam int DELTA_W = 20;
	localparam int SUM_W   = ((USED_W > DELTA_W) ? USED_W : DELTA_W) + 1;

	localparam logic [31:0] FAR_MASK  = 32'hF800_0000;
	localparam logic [31:0] FAR_MARK  = 32'h7800_0000;
	localparam logic [31:0] NEXT_MASK = 32'h003F_FFFF;
	localparam logic [31:0] NEG_WORD  = 32'hC000_0000;

	localparam logic [2:0] MODE_WR_TAG  = 3'd0;
	localparam logic [2:0] MODE_WR_FAR  = 3'd1;
	localparam logic [2:0] MODE_WR_NEG  = 3'd2;
	localparam logic [2:0] MODE_INDEX   = 3'd3;
	localparam logic [2:0] MODE_FULL_ID = 3'd4;
	localparam logic [2:0] MODE_FIELD   = 3'd5;
	localparam logic [2:0] MODE_CHAIN   = 3'd6;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_RANGE = 2'd1;
	localparam logic [1:0] ST_CHAIN = 2'd2;
	localparam logic [1:0] ST_CAP   = 2'd3;

	typedef struct packed {
		logic [2:0]  mode;
		logic [20:0] id;
		logic [31:0] tag_word;
		logic [19:0] far_target;
	} in_item_t;

	typedef struct packed {
		logic [31:0] result_value;
		logic [1:0]  status;
		logic        has_triple;
		logic [2:0]  triple_type;
		logic [27:0] triple_value;
		logic [29:0] triple_seq;
		logic        last;
	} out_item_t;

	typedef enum logic [3:0] {
		UOP_NULL,
		UOP_WRITE,
		UOP_LOC_CHK,
		UOP_LOC_FAR,
		UOP_LOC_TAG,
		UOP_LK_NEG,
		UOP_LK_FIELD,
		UOP_CH_FIRST,
		UOP_CH_NEXT,
		UOP_CL_DEC
	} uop_t;

	localparam int UC_DEPTH = 17;
	localparam int UPC_W    = $clog2(UC_DEPTH);
	typedef logic [UPC_W-1:0] upc_t;

	localparam upc_t UA_WR  = UPC_W'(0);
	localparam upc_t UA_NUL = UPC_W'(1);
	localparam upc_t UA_LK0 = UPC_W'(2);
	localparam upc_t UA_LK1 = UPC_W'(3);
	localparam upc_t UA_LK2 = UPC_W'(4);
	localparam upc_t UA_LK3 = UPC_W'(5);
	localparam upc_t UA_LK4 = UPC_W'(6);
	localparam upc_t UA_CF0 = UPC_W'(7);
	localparam upc_t UA_CF1 = UPC_W'(8);
	localparam upc_t UA_CF2 = UPC_W'(9);
	localparam upc_t UA_CF3 = UPC_W'(10);
	localparam upc_t UA_CF4 = UPC_W'(11);
	localparam upc_t UA_CL0 = UPC_W'(12);
	localparam upc_t UA_CL1 = UPC_W'(13);
	localparam upc_t UA_CL2 = UPC_W'(14);
	localparam upc_t UA_CL3 = UPC_W'(15);
	localparam upc_t UA_CL4 = UPC_W'(16);

	typedef struct packed {
		uop_t op;
		upc_t target;
	} ucode_t;

	typedef struct packed {
		logic fin;
		logic br;
	} seq_ctl_t;

	// control store; target only matters on words whose op can branch
	function automatic ucode_t ucode_rom(upc_t a);
		ucode_t w;
		unique case (a)
			UA_WR:   w = '{op: UOP_WRITE,    target: UA_WR};
			UA_NUL:  w = '{op: UOP_NULL,     target: UA_WR};
			UA_LK0:  w = '{op: UOP_LOC_CHK,  target: UA_WR};
			UA_LK1:  w = '{op: UOP_LOC_FAR,  target: UA_LK3};
			UA_LK2:  w = '{op: UOP_LOC_TAG,  target: UA_WR};
			UA_LK3:  w = '{op: UOP_LK_NEG,   target: UA_WR};
			UA_LK4:  w = '{op: UOP_LK_FIELD, target: UA_WR};
			UA_CF0:  w = '{op: UOP_LOC_CHK,  target: UA_WR};
			UA_CF1:  w = '{op: UOP_LOC_FAR,  target: UA_CF3};
			UA_CF2:  w = '{op: UOP_LOC_TAG,  target: UA_WR};
			UA_CF3:  w = '{op: UOP_CH_FIRST, target: UA_WR};
			UA_CF4:  w = '{op: UOP_CH_NEXT,  target: UA_CL0};
			UA_CL0:  w = '{op: UOP_LOC_CHK,  target: UA_WR};
			UA_CL1:  w = '{op: UOP_LOC_FAR,  target: UA_CL3};
			UA_CL2:  w = '{op: UOP_LOC_TAG,  target: UA_WR};
			UA_CL3:  w = '{op: UOP_CL_DEC,   target: UA_CL0};
			UA_CL4:  w = '{op: UOP_CH_NEXT,  target: UA_CL0};
			default: w = '{op: UOP_NULL,     target: UA_WR};
		endcase
		return w;
	endfunction

	function automatic upc_t entry_of(logic [2:0] mode);
		upc_t a;
		unique case (mode) inside
			MODE_WR_TAG, MODE_WR_FAR, MODE_WR_NEG: a = UA_WR;
			MODE_INDEX, MODE_FULL_ID, MODE_FIELD:  a = UA_LK0;
			MODE_CHAIN:                            a = UA_CF0;
			default:                               a = UA_NUL;
		endcase
		return a;
	endfunction

endpackage

// ----- hw/rtl/iite_useq.sv -----
// Microcode sequencer of the indirect id table engine: step counter,
// control store read and conditional jumps. Depends on iite_pkg.
module iite_useq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               go,
	input  logic [2:0]         mode,
	input  iite_pkg::seq_ctl_t ctl,
	output logic               active,
	output iite_pkg::ucode_t   uword
);
	import iite_pkg::*;

	logic active_q;
	upc_t upc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			upc_q    <= '0;
		end else if (go) begin
			active_q <= 1'b1;
			upc_q    <= entry_of(mode);
		end else if (active_q) begin
			if (ctl.fin) begin
				active_q <= 1'b0;
			end else if (ctl.br) begin
				upc_q <= uword.target;
			end else begin
				upc_q <= upc_q + UPC_W'(1);
			end
		end
	end

	assign uword  = ucode_rom(upc_q);
	assign active = active_q;

endmodule

// ----- hw/rtl/indirect_id_table_engine.sv -----
// Top level of the indirect id table engine: tag memory, datapath and
// result register. Depends on iite_pkg, iite_useq and assert_macros.svh.
//
//  channel  | ports               | transfer
//  ---------+---------------------+--------------------------------------
//  command  | start, busy, item   | edge with start high and busy low
//  result   | result_stb, result  | every edge that ends a strobe cycle
//
// Write and unused mode end in their first step. A lookup checks the id
// and reads its word of the single-port tag memory, follows a far word
// with one more read, checks the tag and may read the field word in field
// mode. A chain emits a triple per link. A result is registered and shows
// in the cycle after its step. After reset busy stays high while all the
// memory is cleared. The receiver cannot stall; results are never held.
`include "assert_macros.svh"

module indirect_id_table_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  iite_pkg::in_item_t  item,
	output logic                result_stb,
	output iite_pkg::out_item_t result
);
	import iite_pkg::*;

	logic              seq_act;
	logic              go;
	ucode_t            uword;
	seq_ctl_t          ctl;

	logic              clr_act_q;
	logic [ADDR_W-1:0] clr_addr_q;

	logic [31:0]       tag_mem [TABLE_DEPTH];
	logic [31:0]       rdata_q;
	logic              mem_we, mem_rd, mem_wr_op;
	logic [ADDR_W-1:0] mem_addr, op_addr;
	logic [31:0]       mem_wdata, op_wdata;

	in_item_t          item_q;
	logic [31:0]       key_q, key_d;
	logic [USED_W-1:0] idx_q, idx_d;
	logic [29:0]       seq_q, seq_d;
	logic [31:0]       tag_q, tag_d;
	logic [CNT_W-1:0]  cnt_q, cnt_d;
	logic [USED_W-1:0] used_q, used_d;
	logic              emit;
	out_item_t         out_d, result_q;
	logic              result_stb_q;

	logic [KIDX_W-1:0]  key_idx;
	logic               rng_fail, lim_fail;
	logic               is_far, far_fail;
	logic [DELTA_W-1:0] delta;
	logic [SUM_W-1:0]   far_sum;
	logic               tag_neg, idx_hi;
	logic [27:0]        wide1, fld1;
	logic [31:0]        nxt_tag;
	logic [10:0]        widx;
	logic [31:0]        wr_word;

	assign busy = clr_act_q | seq_act;
	assign go   = start & ~busy;

	iite_useq u_useq (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go),
		.mode   (item.mode),
		.ctl    (ctl),
		.active (seq_act),
		.uword  (uword)
	);

	assign key_idx  = key_q[31:10];
	assign rng_fail = (key_idx == '0) || (key_idx > KIDX_W'(used_q));
	assign lim_fail = (item_q.mode == MODE_CHAIN) && (cnt_q >= CNT_W'(CHAIN_LIMIT));
	assign is_far   = (rdata_q & FAR_MASK) == FAR_MARK;
	assign delta    = rdata_q[DELTA_W-1:0];
	assign far_sum  = SUM_W'(idx_q) + SUM_W'(delta);
	assign far_fail = far_sum > SUM_W'(used_q);
	assign tag_neg  = tag_q[31] & tag_q[30];
	assign idx_hi   = idx_q >= used_q;
	assign wide1    = 28'(tag_q[26:0]) + 28'd1;
	assign fld1     = 28'(tag_q[26:22]) + 28'd1;
	assign nxt_tag  = tag_q & NEXT_MASK;
	assign widx     = item_q.id[20:10];

	always_comb begin
		case (item_q.mode)
			MODE_WR_FAR: wr_word = FAR_MARK | 32'(item_q.far_target);
			MODE_WR_NEG: wr_word = NEG_WORD;
			default:     wr_word = item_q.tag_word;
		endcase
	end

	always_comb begin
		ctl       = '0;
		emit      = 1'b0;
		out_d     = '0;
		mem_rd    = 1'b0;
		mem_wr_op = 1'b0;
		op_addr   = '0;
		op_wdata  = wr_word;
		key_d     = key_q;
		idx_d     = idx_q;
		seq_d     = seq_q;
		tag_d     = tag_q;
		cnt_d     = cnt_q;
		used_d    = used_q;
		if (seq_act) begin
			unique case (uword.op)
				UOP_WRITE: begin
					ctl.fin = 1'b1;
					if (widx == '0) begin
						out_d.status = ST_RANGE;
					end else if (32'(widx) > TABLE_DEPTH) begin
						out_d.status = ST_CAP;
					end else begin
						mem_wr_op = 1'b1;
						op_addr   = ADDR_W'(widx - 11'd1);
						if (USED_W'(widx) > used_q) begin
							used_d = USED_W'(widx);
						end
					end
				end
				UOP_LOC_CHK: begin
					if ((item_q.mode != MODE_CHAIN) && (key_q == '0)) begin
						ctl.fin = 1'b1;
					end else if (lim_fail) begin
						ctl.fin      = 1'b1;
						out_d.status = ST_CHAIN;
					end else if (rng_fail) begin
						ctl.fin      = 1'b1;
						out_d.status = ST_RANGE;
					end else begin
						mem_rd  = 1'b1;
						op_addr = ADDR_W'(key_idx - KIDX_W'(1));
						idx_d   = USED_W'(key_idx);
						seq_d   = 30'(key_q[9:0]);
					end
				end
				UOP_LOC_FAR: begin
					if (!is_far) begin
						tag_d  = rdata_q;
						ctl.br = 1'b1;
					end else if (far_fail) begin
						ctl.fin      = 1'b1;
						out_d.status = ST_RANGE;
					end else begin
						mem_rd  = 1'b1;
						op_addr = ADDR_W'(far_sum - SUM_W'(1));
						idx_d   = USED_W'(far_sum);
						seq_d   = seq_q | {delta, 10'd0};
					end
				end
				UOP_LOC_TAG: begin
					tag_d = rdata_q;
				end
				UOP_LK_NEG: begin
					if (tag_neg && idx_hi) begin
						ctl.fin      = 1'b1;
						out_d.status = ST_RANGE;
					end else if (tag_neg && (item_q.mode == MODE_FIELD)) begin
						mem_rd  = 1'b1;
						op_addr = ADDR_W'(idx_q);
					end else begin
						ctl.fin = 1'b1;
						if (item_q.mode == MODE_INDEX) begin
							out_d.result_value = 32'(idx_q);
						end else if (item_q.mode == MODE_FULL_ID) begin
							out_d.result_value = 32'(seq_q);
						end else if (tag_q[30]) begin
							out_d.result_value = nxt_tag;
						end
					end
				end
				UOP_LK_FIELD: begin
					ctl.fin            = 1'b1;
					out_d.result_value = rdata_q;
				end
				UOP_CH_FIRST: begin
					if (idx_hi) begin
						ctl.fin      = 1'b1;
						out_d.status = ST_RANGE;
					end else begin
						mem_rd  = 1'b1;
						op_addr = ADDR_W'(idx_q);
					end
				end
				UOP_CH_NEXT: begin
					emit               = 1'b1;
					out_d.has_triple   = 1'b1;
					out_d.triple_type  = tag_q[29:27];
					out_d.triple_value = wide1;
					out_d.triple_seq   = seq_q;
					key_d              = rdata_q;
					cnt_d              = cnt_q + CNT_W'(1);
					if (rdata_q == '0) begin
						ctl.fin = 1'b1;
					end else begin
						ctl.br = 1'b1;
					end
				end
				UOP_CL_DEC: begin
					if (!tag_q[30]) begin
						ctl.fin            = 1'b1;
						out_d.has_triple   = 1'b1;
						out_d.triple_type  = tag_q[29:27];
						out_d.triple_value = tag_q[31] ? wide1 : fld1;
						out_d.triple_seq   = seq_q;
					end else if (!tag_q[31]) begin
						emit               = 1'b1;
						out_d.has_triple   = 1'b1;
						out_d.triple_type  = tag_q[29:27];
						out_d.triple_value = fld1;
						out_d.triple_seq   = seq_q;
						key_d              = nxt_tag;
						cnt_d              = cnt_q + CNT_W'(1);
						if (nxt_tag == '0) begin
							ctl.fin = 1'b1;
						end else begin
							ctl.br = 1'b1;
						end
					end else if (idx_hi) begin
						ctl.fin      = 1'b1;
						out_d.status = ST_RANGE;
					end else begin
						mem_rd  = 1'b1;
						op_addr = ADDR_W'(idx_q);
					end
				end
				default: begin
					ctl.fin = 1'b1;
				end
			endcase
		end
		emit       = emit | ctl.fin;
		out_d.last = ctl.fin;
	end

	assign mem_we    = clr_act_q | mem_wr_op;
	assign mem_addr  = clr_act_q ? clr_addr_q : op_addr;
	assign mem_wdata = clr_act_q ? '0 : op_wdata;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tag_mem[mem_addr] <= mem_wdata;
		end
		if (mem_rd) begin
			rdata_q <= tag_mem[mem_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_act_q    <= 1'b1;
			clr_addr_q   <= '0;
			used_q       <= '0;
			cnt_q        <= '0;
			result_stb_q <= 1'b0;
		end else begin
			if (clr_act_q) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
				if (clr_addr_q == ADDR_W'(TABLE_DEPTH - 1)) begin
					clr_act_q <= 1'b0;
				end
			end
			used_q       <= used_d;
			cnt_q        <= go ? '0 : cnt_d;
			result_stb_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			item_q <= item;
			key_q  <= 32'(item.id);
		end else begin
			key_q <= key_d;
		end
		idx_q    <= idx_d;
		seq_q    <= seq_d;
		tag_q    <= tag_d;
		result_q <= out_d;
	end

	assign result_stb = result_stb_q;
	assign result     = result_q;

	`ASSERT_NEVER(a_used_cap, clk, arst_n, 32'(used_q) > TABLE_DEPTH)
	`ASSERT_NEVER(a_clr_excl, clk, arst_n, clr_act_q && seq_act)
	`ASSERT_NEVER(a_fin_br, clk, arst_n, ctl.fin && ctl.br)
	`ASSERT_NEVER(a_cnt_lim, clk, arst_n, 32'(cnt_q) > CHAIN_LIMIT)
	`ASSERT_PROP(a_last_idle, clk, arst_n, (result_stb && result.last) |-> !busy)
	`ASSERT_PROP(a_mid_triple, clk, arst_n, (result_stb && !result.last) |-> result.has_triple)

endmodule
